// ===== rtl/core/htd_pkg.sv =====
// Shared types, codes and fixed field widths for the Huffman tree decoder.
// No dependencies; htd_if, htd_ctrl and the top level import this package.
package htd_pkg;

	localparam int SYM_W        = 10;
	localparam int BITS_W       = 32;
	localparam int LEN_W        = 6;
	localparam int MAX_SYMBOLS  = 1024;
	localparam int MAX_CODE_LEN = 32;

	// Clamp limits for load items
	localparam logic [16:0]      SYM_LIM = 17'(MAX_SYMBOLS);
	localparam logic [SYM_W-1:0] SYM_TOP = SYM_W'(MAX_SYMBOLS - 1);
	localparam logic [LEN_W:0]   LEN_LIM = (LEN_W + 1)'(MAX_CODE_LEN);
	localparam logic [LEN_W-1:0] LEN_TOP = LEN_W'(MAX_CODE_LEN);

	// Action codes
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_LOAD   = 2'd1;
	localparam logic [1:0] ACT_DECODE = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0]        action;
		logic [BITS_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_len;
		logic [SYM_W-1:0]  load_symbol;
		logic              coded_bit;
	} cmd_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic [1:0]       status;
	} res_item_t;

	typedef struct packed {
		logic      valid;
		res_item_t item;
	} emit_t;

	// Path bit at a position; positions past the code word read as 0
	function automatic logic path_bit(logic [BITS_W-1:0] bits, logic [LEN_W-1:0] pos);
		return pos[LEN_W-1] ? 1'b0 : bits[pos[LEN_W-2:0]];
	endfunction

endpackage

// ===== rtl/core/htd_if.sv =====
// Valid/ready channel interfaces for command items and result items.
// Depends on htd_pkg for the payload structs.
interface htd_cmd_if import htd_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface htd_res_if import htd_pkg::*; ();
	logic      valid;
	logic      ready;
	res_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/htd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module htd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// Hold read data while no read is issued
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/htd_ctrl.sv =====
// Sequencer for the Huffman tree decoder: tree walk, node allocation and decode steps.
// Depends on htd_pkg; drives the node table RAM ports and the result register.
module htd_ctrl import htd_pkg::*; #(
	parameter int MAX_NODES = 2048
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cmd_take,
	input  cmd_item_t                                  cmd_item,
	output logic                                       idle,
	input  logic                                       res_free,
	output emit_t                                      emit,
	output logic                                       rd_en,
	output logic [$clog2(MAX_NODES)-1:0]               rd_addr,
	input  logic [2*$clog2(MAX_NODES)+SYM_W-1:0]       rd_data,
	output logic                                       wr_en,
	output logic [$clog2(MAX_NODES)-1:0]               wr_addr,
	output logic [2*$clog2(MAX_NODES)+SYM_W-1:0]       wr_data
);

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int NU_W   = $clog2(MAX_NODES + 1);
	localparam int ENT_W  = 2 * NODE_W + SYM_W;
	localparam int SUM_W  = ((NU_W > LEN_W) ? NU_W : LEN_W) + 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_WALK  = 5'b00010,
		S_NEW   = 5'b00100,
		S_DSTEP = 5'b01000,
		S_DLEAF = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	logic [NODE_W-1:0]   root_l_q, root_l_d, root_r_q, root_r_d;
	logic [NU_W-1:0]     nodes_q, nodes_d;
	logic [NODE_W-1:0]   cur_q, cur_d;
	logic                view_root_q, view_root_d;
	logic [NODE_W-1:0]   node_q, node_d, next_q, next_d;
	logic [LEN_W-1:0]    i_q, i_d, len_q, len_d;
	logic [BITS_W-1:0]   bits_q, bits_d;
	logic [SYM_W-1:0]    sym_q, sym_d;
	logic                dir_q, dir_d;

	logic [NODE_W-1:0]   v_left, v_right, child, nxt, new_idx, next_new;
	logic [SYM_W-1:0]    v_sym;
	logic [LEN_W-1:0]    len_last, need, len_eff;
	logic                wbit, nbit, last, full;
	logic [ENT_W-1:0]    leaf_ent;

	// Entry of the node under inspection: root lives in flops, others in RAM
	assign v_left   = view_root_q ? root_l_q : rd_data[ENT_W-1 -: NODE_W];
	assign v_right  = view_root_q ? root_r_q : rd_data[NODE_W+SYM_W-1 -: NODE_W];
	assign v_sym    = rd_data[SYM_W-1:0];

	assign len_last = len_q - LEN_W'(1);
	assign last     = (i_q == len_last);
	assign wbit     = path_bit(bits_q, len_last - i_q);
	assign nbit     = path_bit(bits_q, len_last - i_q - LEN_W'(1));
	assign child    = wbit ? v_right : v_left;
	assign nxt      = dir_q ? v_right : v_left;
	assign need     = len_q - i_q;
	assign full     = (SUM_W'(nodes_q) + SUM_W'(need)) > SUM_W'(MAX_NODES);
	assign new_idx  = nodes_q[NODE_W-1:0];
	assign next_new = new_idx + NODE_W'(1);
	assign leaf_ent = {{NODE_W{1'b0}}, {NODE_W{1'b0}}, sym_q};
	assign len_eff  = ({1'b0, cmd_item.code_len} > LEN_LIM) ? LEN_TOP : cmd_item.code_len;

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		root_l_d    = root_l_q;
		root_r_d    = root_r_q;
		nodes_d     = nodes_q;
		cur_d       = cur_q;
		view_root_d = view_root_q;
		node_d      = node_q;
		next_d      = next_q;
		i_d         = i_q;
		len_d       = len_q;
		bits_d      = bits_q;
		sym_d       = sym_q;
		dir_d       = dir_q;
		rd_en       = 1'b0;
		rd_addr     = cur_q;
		wr_en       = 1'b0;
		wr_addr     = node_q;
		wr_data     = leaf_ent;
		emit        = '0;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_take) begin
					unique case (cmd_item.action)
						ACT_CLEAR: begin
							root_l_d = '0;
							root_r_d = '0;
							nodes_d  = NU_W'(1);
							cur_d    = '0;
						end
						ACT_LOAD: begin
							if (len_eff != '0) begin
								bits_d      = cmd_item.code_bits;
								len_d       = len_eff;
								sym_d       = ({7'd0, cmd_item.load_symbol} >= SYM_LIM) ?
									SYM_TOP : cmd_item.load_symbol;
								i_d         = '0;
								node_d      = '0;
								view_root_d = 1'b1;
								state_d     = S_WALK;
							end
						end
						ACT_DECODE: begin
							dir_d       = cmd_item.coded_bit;
							view_root_d = (cur_q == '0);
							rd_en       = (cur_q != '0);
							rd_addr     = cur_q;
							state_d     = S_DSTEP;
						end
						default: ;
					endcase
				end
			end
			S_WALK: begin
				if (child != '0) begin
					if (last) begin
						// Whole path exists: the end node becomes a leaf
						wr_en   = 1'b1;
						wr_addr = child;
						wr_data = leaf_ent;
						state_d = S_IDLE;
					end else begin
						rd_en       = 1'b1;
						rd_addr     = child;
						node_d      = child;
						view_root_d = 1'b0;
						i_d         = i_q + LEN_W'(1);
					end
				end else if (full) begin
					if (res_free) begin
						emit.valid       = 1'b1;
						emit.item.symbol = '0;
						emit.item.status = ST_FULL;
						state_d          = S_IDLE;
					end
				end else begin
					// Link the first new node under the last existing one
					if (view_root_q) begin
						if (wbit) begin
							root_r_d = new_idx;
						end else begin
							root_l_d = new_idx;
						end
					end else begin
						wr_en   = 1'b1;
						wr_addr = node_q;
						wr_data = wbit ? {v_left, new_idx, v_sym} : {new_idx, v_right, v_sym};
					end
					state_d = S_NEW;
				end
			end
			S_NEW: begin
				wr_en   = 1'b1;
				wr_addr = new_idx;
				nodes_d = nodes_q + NU_W'(1);
				i_d     = i_q + LEN_W'(1);
				if (last) begin
					wr_data = leaf_ent;
					state_d = S_IDLE;
				end else begin
					wr_data = nbit ? {{NODE_W{1'b0}}, next_new, {SYM_W{1'b0}}} :
						{next_new, {NODE_W{1'b0}}, {SYM_W{1'b0}}};
				end
			end
			S_DSTEP: begin
				if (nxt == '0) begin
					if (res_free) begin
						emit.valid       = 1'b1;
						emit.item.symbol = '0;
						emit.item.status = ST_MISSING;
						cur_d            = '0;
						state_d          = S_IDLE;
					end
				end else begin
					rd_en       = 1'b1;
					rd_addr     = nxt;
					next_d      = nxt;
					view_root_d = 1'b0;
					state_d     = S_DLEAF;
				end
			end
			S_DLEAF: begin
				if (v_left == '0 && v_right == '0) begin
					if (res_free) begin
						emit.valid       = 1'b1;
						emit.item.symbol = v_sym;
						emit.item.status = ST_OK;
						cur_d            = '0;
						state_d          = S_IDLE;
					end
				end else begin
					cur_d   = next_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			root_l_q    <= '0;
			root_r_q    <= '0;
			nodes_q     <= NU_W'(1);
			cur_q       <= '0;
			view_root_q <= 1'b1;
		end else begin
			state_q     <= state_d;
			root_l_q    <= root_l_d;
			root_r_q    <= root_r_d;
			nodes_q     <= nodes_d;
			cur_q       <= cur_d;
			view_root_q <= view_root_d;
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_d;
		next_q <= next_d;
		i_q    <= i_d;
		len_q  <= len_d;
		bits_q <= bits_d;
		sym_q  <= sym_d;
		dir_q  <= dir_d;
	end

endmodule

// ===== rtl/core/huffman_tree_decoder.sv =====
// Top level of the Huffman tree decoder: command and result channels, result register.
// Depends on htd_pkg, htd_if, htd_ram and htd_ctrl.
//
// Usage: items arrive on cmd (valid/ready); action selects clear table, load one code
// or decode one stream bit. Results (symbol, status) leave on res, at most one per item:
// a decoded symbol, a missing branch (decoder restarts at the root) or a full node table
// on load (the table is left untouched).
// The tree lives in one node RAM (left child, right child, leaf symbol per entry) with a
// registered read; the root's children sit in flops so that reset and clear
// take effect at once, with no clearing pass. Unused RAM entries are never read.
// Timing: the block takes one item at a time; cmd.ready is high only while idle.
//   clear, unused action, empty load: handled without leaving idle.
//   decode: read the current node, then the child; a missing branch stops before the child read.
//   load: walk the existing path nodes (one RAM read per cycle); if the path is incomplete,
//     either report a full table or write the link and then the new nodes (one RAM write
//     per cycle).
// A result lands in an output register in the cycle after it is emitted. If that register
// still holds an untaken result, the sequencer holds at the point of emitting, so no
// result is lost; a further item may be accepted while a result waits.
// Reset (arst_n low): empty tree with a lone root, decoder at the root, res empty.
module huffman_tree_decoder import htd_pkg::*; #(
	parameter int MAX_NODES = 2048
) (
	input  logic      clk,
	input  logic      arst_n,
	htd_cmd_if.sink   cmd,
	htd_res_if.source res
);

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int ENT_W  = 2 * NODE_W + SYM_W;

	logic              idle;
	logic              cmd_take;
	logic              res_free;
	emit_t             emit;
	logic              rd_en, wr_en;
	logic [NODE_W-1:0] rd_addr, wr_addr;
	logic [ENT_W-1:0]  rd_data, wr_data;
	logic              out_valid_q;
	res_item_t         out_item_q;

	// Accept only while the sequencer is idle
	assign cmd.ready = idle;
	assign cmd_take  = cmd.valid && cmd.ready;

	// Room for a new result: register empty or being drained this cycle
	assign res_free    = !out_valid_q || res.ready;
	assign res.valid   = out_valid_q;
	assign res.payload = out_item_q;

	htd_ctrl #(
		.MAX_NODES(MAX_NODES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_take (cmd_take),
		.cmd_item (cmd.payload),
		.idle     (idle),
		.res_free (res_free),
		.emit     (emit),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	// Node table: one entry per node
	htd_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_NODES)
	) u_nodes (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_item_q <= emit.item;
		end
	end

	// Sequencer never overwrites a result that has not been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> (!out_valid_q || res.ready))
		else $error("result emitted into a full output register");

	// Error results carry symbol zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && emit.item.status != ST_OK) |-> (emit.item.symbol == '0))
		else $error("error result with nonzero symbol");

	// A decode item always keeps the block busy for the following cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && cmd.payload.action == ACT_DECODE) |=> !cmd.ready)
		else $error("decode item did not occupy the sequencer");

endmodule
